// ----- src/vtp_pkg.sv -----
// shared types and constants of the vertex transform with perspective divide
package vtp_pkg;

  localparam int unsigned NumRegs    = 8;
  localparam int unsigned CfgIdxW    = 4;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned DivSteps   = 48;
  localparam logic [31:0] OneQ16     = 32'h0001_0000;
  localparam logic [31:0] SatMax     = 32'h7fff_ffff;
  localparam logic [31:0] SatMin     = 32'h8000_0000;

  // identity matrix after reset
  localparam logic [NumRegs-1:0][CfgDataW-1:0] CfgReset = {
    64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
    64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000
  };

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } in_t;

  typedef struct packed {
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
  } out_t;

  // transformed point between front and back
  typedef struct packed {
    logic [2:0][31:0] v;
    logic [31:0]      w;
    logic             dv;
  } xfm_t;

  // queue handshake toward the front
  typedef struct packed {
    logic push;
    logic full;
  } qwr_t;

  // queue handshake toward the back
  typedef struct packed {
    logic pop;
    logic empty;
  } qrd_t;

endpackage

// ----- src/vtp_front.sv -----
// front part: matrix registers, products, row sums, saturation and w check
module vtp_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [vtp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [vtp_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  vtp_pkg::in_t               in_req_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output vtp_pkg::xfm_t              q_data_o
);
  import vtp_pkg::*;

  logic [NumRegs-1:0][CfgDataW-1:0] cfg_q;
  logic signed [2:0][31:0]          pnt;
  logic signed [3:0][2:0][63:0]     prod_q;
  logic signed [3:0][65:0]          sum_q;
  logic [1:0]                       s_v_q;
  logic                             en;
  logic [3:0][31:0]                 rowv;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i && (cfg_idx_i < CfgIdxW'(NumRegs))) begin
      cfg_q[cfg_idx_i[2:0]] <= cfg_data_i;
    end
  end

  assign pnt = {in_req_i.px, in_req_i.py, in_req_i.pz};
  assign en  = !s_v_q[1] || !q_full_i;
  assign in_ready_o = en;

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_v_q <= '0;
    end else if (en) begin
      s_v_q <= {s_v_q[0], in_valid_i};
    end
  end

  // products and row sums
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= $signed(cfg_q[r*2 + c/2][(c%2)*32 +: 32]) * $signed(pnt[2-c]);
        end
        sum_q[r] <= 66'($signed(prod_q[r][0])) + 66'($signed(prod_q[r][1]))
                  + 66'($signed(prod_q[r][2]))
                  + (66'($signed(cfg_q[r*2+1][63:32])) <<< 16);
      end
    end
  end

  // floor shift by 16 and saturation
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      if (sum_q[r][65:47] != {19{sum_q[r][65]}}) begin
        rowv[r] = sum_q[r][65] ? SatMin : SatMax;
      end else begin
        rowv[r] = sum_q[r][47:16];
      end
    end
  end

  assign q_push_o      = s_v_q[1] && !q_full_i;
  assign q_data_o.v    = {rowv[2], rowv[1], rowv[0]};
  assign q_data_o.w    = rowv[3];
  assign q_data_o.dv   = (rowv[3] != OneQ16) && (rowv[3] != 32'h0);

endmodule

// ----- src/vtp_queue.sv -----
// short queue between front and back
module vtp_queue #(
  parameter int unsigned Depth = vtp_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  output vtp_pkg::qwr_t  wr_o,
  input  logic           push_i,
  input  vtp_pkg::xfm_t  data_i,
  output vtp_pkg::qrd_t  rd_o,
  input  logic           pop_i,
  output vtp_pkg::xfm_t  data_o
);
  import vtp_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  xfm_t            mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q;

  assign wr_o.full  = cnt_q == CntW'(Depth);
  assign wr_o.push  = push_i;
  assign rd_o.empty = cnt_q == '0;
  assign rd_o.pop   = pop_i;
  assign data_o     = mem_q[rp_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == PtrW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (pop_i)  rp_q <= (rp_q == PtrW'(Depth-1)) ? '0 : rp_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

endmodule

// ----- src/vtp_back.sv -----
// back part: pipelined restoring divide by w and output register
module vtp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  vtp_pkg::xfm_t  q_data_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output vtp_pkg::out_t  out_req_o
);
  import vtp_pkg::*;

  typedef struct packed {
    logic [2:0][31:0] rem;
    logic [2:0][47:0] nq;
    logic [2:0]       neg;
    logic [31:0]      den;
    logic             dv;
    logic [2:0][31:0] v;
  } stg_t;

  stg_t              stg_q [DivSteps+1];
  stg_t              stg_d [DivSteps+1];
  logic [DivSteps:0] stg_v_q;
  logic              en;
  logic              out_v_q;
  out_t              out_q;
  logic [2:0][31:0]  res;

  assign en      = !out_v_q || out_ready_i;
  assign q_pop_o = en && !q_empty_i;

  // load: magnitudes and sign of each quotient
  always_comb begin
    logic [31:0] av;
    stg_d[0]     = '0;
    stg_d[0].dv  = q_data_i.dv;
    stg_d[0].v   = q_data_i.v;
    stg_d[0].den = q_data_i.w[31] ? -q_data_i.w : q_data_i.w;
    for (int i = 0; i < 3; i++) begin
      av = q_data_i.v[i][31] ? -q_data_i.v[i] : q_data_i.v[i];
      stg_d[0].nq[i]  = {av, 16'h0};
      stg_d[0].neg[i] = q_data_i.v[i][31] ^ q_data_i.w[31];
    end
  end

  // one quotient bit per stage
  for (genvar s = 1; s <= DivSteps; s++) begin : g_step
    always_comb begin
      logic [32:0] r2;
      stg_d[s] = stg_q[s-1];
      for (int i = 0; i < 3; i++) begin
        r2 = {stg_q[s-1].rem[i], stg_q[s-1].nq[i][47]};
        if (r2 >= {1'b0, stg_q[s-1].den}) begin
          r2 = r2 - {1'b0, stg_q[s-1].den};
          stg_d[s].nq[i] = {stg_q[s-1].nq[i][46:0], 1'b1};
        end else begin
          stg_d[s].nq[i] = {stg_q[s-1].nq[i][46:0], 1'b0};
        end
        stg_d[s].rem[i] = r2[31:0];
      end
    end
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s <= DivSteps; s++) stg_q[s] <= stg_d[s];
    end
  end

  // sign, saturation and bypass when no divide
  always_comb begin
    logic [47:0] q;
    for (int i = 0; i < 3; i++) begin
      q = stg_q[DivSteps].nq[i];
      if (!stg_q[DivSteps].dv) begin
        res[i] = stg_q[DivSteps].v[i];
      end else if (stg_q[DivSteps].neg[i]) begin
        if ((q[47:32] != '0) || (q[31] && (q[30:0] != '0))) res[i] = SatMin;
        else res[i] = -q[31:0];
      end else begin
        if (q[47:31] != '0) res[i] = SatMax;
        else res[i] = q[31:0];
      end
    end
  end

  // valid bits and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      stg_v_q <= {stg_v_q[DivSteps-1:0], !q_empty_i};
      out_v_q <= stg_v_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= {res[0], res[1], res[2]};
  end

  assign out_valid_o = out_v_q;
  assign out_req_o   = out_q;

endmodule

// ----- src/vertex_transform_perspective.sv -----
// top level of the 4x4 vertex transform with perspective divide
// throughput: one point per cycle when nothing stalls; set by the 48-stage divide pipeline
// and the front multiplier stage, one new point entering each cycle
// a 4-entry queue lets the front keep accepting while the output stalls
// reset: asynchronous active low; matrix returns to identity, pipeline empties
module vertex_transform_perspective #(
  parameter int unsigned QueueDepth = vtp_pkg::QueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [vtp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [vtp_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  vtp_pkg::in_t                in_req_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output vtp_pkg::out_t               out_req_o
);
  import vtp_pkg::*;

  qwr_t qwr;
  qrd_t qrd;
  logic push, pop;
  xfm_t wdata, rdata;

  // accept and transform
  vtp_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_req_i,
    .q_full_i (qwr.full), .q_push_o (push), .q_data_o (wdata)
  );

  // decoupling queue
  vtp_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .wr_o (qwr), .push_i (push), .data_i (wdata),
    .rd_o (qrd), .pop_i (pop), .data_o (rdata)
  );

  // divide and deliver
  vtp_back u_back (
    .clk_i, .rst_ni,
    .q_empty_i (qrd.empty), .q_data_i (rdata), .q_pop_o (pop),
    .out_valid_o, .out_ready_i, .out_req_o
  );

endmodule

// ----- src/vtp_checker.sv -----
// port checks of the vertex transform and their bind
module vtp_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input vtp_pkg::out_t out_req_o
);

  // stalled result request stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result request dropped while stalled");

  // stalled result payload holds
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_req_o))
    else $error("result payload changed while stalled");

  // no result during reset
  a_rst_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result offered during reset");

  // empty pipeline takes requests right after reset and has nothing to show
  a_rst_ready: assert property (@(posedge clk_i)
    rst_ni && $past(!rst_ni) |-> in_ready_o && !out_valid_o ##1 !out_valid_o)
    else $error("pipeline not empty after reset");

endmodule

bind vertex_transform_perspective vtp_checker u_vtp_checker (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i, .out_req_o
);
